FILE: src/a2x_pkg.sv
// shared types, constants and helper functions for the arm2 execute unit
`timescale 1ns / 1ps

package a2x_pkg;

    localparam int WORD_W    = 32;
    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = 4;
    localparam int PC_STEP_W = 24;

    localparam logic [REG_IDX_W-1:0] PC_IDX   = 4'd15;
    localparam logic [REG_IDX_W-1:0] LINK_IDX = 4'd14;

    localparam logic [WORD_W-1:0] PC_FIELD  = 32'h03fffffc;
    localparam logic [WORD_W-1:0] PC_KEEP   = 32'hfc000003;
    localparam logic [WORD_W-1:0] PSR_KEEP  = 32'h0c000003;
    localparam logic [15:0]       LOGIC_OPS = 16'hf303;

    localparam logic [WORD_W-1:0] MUL_MASK  = 32'h0fc000f0;
    localparam logic [WORD_W-1:0] MUL_MATCH = 32'h00000090;
    localparam logic [WORD_W-1:0] BR_MASK   = 32'h0e000000;
    localparam logic [WORD_W-1:0] BR_MATCH  = 32'h0a000000;

    typedef enum logic [2:0] {
        OUT_SKIP   = 3'd0,
        OUT_DP     = 3'd1,
        OUT_BRANCH = 3'd2,
        OUT_MUL    = 3'd3,
        OUT_UNSUP  = 3'd4
    } t_outcome;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,  OP_EOR = 4'd1,  OP_SUB = 4'd2,  OP_RSB = 4'd3,
        OP_ADD = 4'd4,  OP_ADC = 4'd5,  OP_SBC = 4'd6,  OP_RSC = 4'd7,
        OP_TST = 4'd8,  OP_TEQ = 4'd9,  OP_CMP = 4'd10, OP_CMN = 4'd11,
        OP_ORR = 4'd12, OP_MOV = 4'd13, OP_BIC = 4'd14, OP_MVN = 4'd15
    } t_dp_op;

    typedef enum logic [3:0] {
        COND_EQ = 4'd0,  COND_NE = 4'd1,  COND_CS = 4'd2,  COND_CC = 4'd3,
        COND_MI = 4'd4,  COND_PL = 4'd5,  COND_VS = 4'd6,  COND_VC = 4'd7,
        COND_HI = 4'd8,  COND_LS = 4'd9,  COND_GE = 4'd10, COND_LT = 4'd11,
        COND_GT = 4'd12, COND_LE = 4'd13, COND_AL = 4'd14, COND_NV = 4'd15
    } t_cond;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic              carry;
        logic [WORD_W-1:0] value;
    } t_shift_out;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [WORD_W-1:0]    data;
    } t_wr_port;

    typedef struct packed {
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] s;
        logic [WORD_W-1:0] c;
    } t_operands;

    typedef struct packed {
        t_outcome             outcome;
        logic                 reg_written;
        logic [REG_IDX_W-1:0] dest_index;
        logic [WORD_W-1:0]    dest_value;
        t_flags               flags;
        logic [WORD_W-1:0]    pc_word;
    } t_exec;

    // advance the pc field by a number of words, wrapping inside bits 25..2
    function automatic logic [WORD_W-1:0] pc_plus(input logic [WORD_W-1:0] w,
                                                  input logic [PC_STEP_W-1:0] d);
        return {w[31:26], w[25:2] + d, w[1:0]};
    endfunction

    function automatic logic is_mul(input logic [WORD_W-1:0] w);
        return (w & MUL_MASK) == MUL_MATCH;
    endfunction

    function automatic logic is_branch(input logic [WORD_W-1:0] w);
        return (w & BR_MASK) == BR_MATCH;
    endfunction

    // register form with bits 7 and 4 set is not data processing
    function automatic logic is_dp(input logic [WORD_W-1:0] w);
        return (w[27:26] == 2'b00) && !(!w[25] && w[7] && w[4]);
    endfunction

    function automatic logic cond_pass(input t_cond cc, input t_flags f);
        logic r;
        case (cc)
            COND_EQ: r = f.z;
            COND_NE: r = !f.z;
            COND_CS: r = f.c;
            COND_CC: r = !f.c;
            COND_MI: r = f.n;
            COND_PL: r = !f.n;
            COND_VS: r = f.v;
            COND_VC: r = !f.v;
            COND_HI: r = f.c && !f.z;
            COND_LS: r = !(f.c && !f.z);
            COND_GE: r = (f.n == f.v);
            COND_LT: r = (f.n != f.v);
            COND_GT: r = !f.z && (f.n == f.v);
            COND_LE: r = !(!f.z && (f.n == f.v));
            COND_AL: r = 1'b1;
            COND_NV: r = 1'b0;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // barrel shifter with the immediate-amount special forms
    function automatic t_shift_out barrel(input logic [WORD_W-1:0] v, input t_shift sh,
                                          input logic [7:0] amt, input logic by_reg,
                                          input logic cin);
        t_shift_out         r;
        logic [7:0]         n;
        logic [5:0]         k;
        logic [WORD_W:0]    t;
        logic [2*WORD_W-1:0] rr;
        r.carry = cin;
        r.value = v;
        n = amt;
        k = 6'd0;
        t = '0;
        rr = '0;
        if (!by_reg && sh == SH_ROR && n == 8'd0) begin
            // rrx
            r.carry = v[0];
            r.value = {cin, v[31:1]};
        end else begin
            if (!by_reg && (sh == SH_LSR || sh == SH_ASR) && n == 8'd0) begin
                n = 8'd32;
            end
            k = (n > 8'd32) ? 6'd32 : n[5:0];
            if (n != 8'd0) begin
                case (sh)
                    SH_LSL: begin
                        t = {1'b0, v} << k;
                        r.carry = (n > 8'd32) ? 1'b0 : t[32];
                        r.value = (n > 8'd32) ? '0 : t[31:0];
                    end
                    SH_LSR: begin
                        t = {v, 1'b0} >> k;
                        r.carry = (n > 8'd32) ? 1'b0 : t[0];
                        r.value = (n > 8'd32) ? '0 : t[32:1];
                    end
                    SH_ASR: begin
                        t = 33'($signed({v, 1'b0}) >>> k);
                        r.carry = t[0];
                        r.value = t[32:1];
                    end
                    SH_ROR: begin
                        if (n[4:0] == 5'd0) begin
                            r.carry = v[31];
                        end else begin
                            rr = {v, v} >> n[4:0];
                            r.value = rr[31:0];
                            r.carry = rr[31];
                        end
                    end
                    default: begin
                        r.value = v;
                    end
                endcase
            end
        end
        return r;
    endfunction

endpackage

FILE: src/a2x_if.sv
// valid/ready channel interfaces for instruction beats and result beats
`timescale 1ns / 1ps

interface a2x_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink (input valid, input instruction_word, output ready);
endinterface

interface a2x_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  outcome;
    logic        reg_written;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic [31:0] pc_word;

    modport source (
        output valid, output outcome, output reg_written, output dest_index,
        output dest_value, output flag_n, output flag_z, output flag_c,
        output flag_v, output pc_word, input ready
    );
    modport sink (
        input valid, input outcome, input reg_written, input dest_index,
        input dest_value, input flag_n, input flag_z, input flag_c,
        input flag_v, input pc_word, output ready
    );
    modport monitor (
        input valid, input outcome, input reg_written, input dest_index,
        input dest_value, input flag_n, input flag_z, input flag_c,
        input flag_v, input pc_word, input ready
    );
endinterface

FILE: src/a2x_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module a2x_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/a2x_regfile.sv
// general register file: three read ports, write bypass, reset valid bits
`timescale 1ns / 1ps

module a2x_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [31:0]         i_word,
    input  a2x_pkg::t_wr_port   i_wr,
    input  logic [31:0]         i_pc,
    output a2x_pkg::t_operands  o_ops
);
    import a2x_pkg::*;

    localparam int PORTS  = 3;
    localparam int PORT_M = 0;
    localparam int PORT_S = 1;
    localparam int PORT_C = 2;

    logic [REG_IDX_W-1:0] w_addr [PORTS];
    logic [WORD_W-1:0]    w_q    [PORTS];
    logic [WORD_W-1:0]    w_val  [PORTS];
    logic [PORTS-1:0]     r_fwd_hit;
    logic [PORTS-1:0]     r_vld;
    logic [PORTS-1:0]     r_is_pc;
    logic [WORD_W-1:0]    r_fwd_data;
    logic [REG_COUNT-1:0] r_valid;

    // third port reads the accumulate register for multiplies, rn otherwise
    assign w_addr[PORT_M] = i_word[3:0];
    assign w_addr[PORT_S] = i_word[11:8];
    assign w_addr[PORT_C] = is_mul(i_word) ? i_word[15:12] : i_word[19:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr.data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < PORTS; g++) begin : g_port
            a2x_ram #(
                .WIDTH (WORD_W),
                .DEPTH (REG_COUNT)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (i_wr.en),
                .i_waddr (i_wr.addr),
                .i_wdata (i_wr.data),
                .i_re    (i_rd_en),
                .i_raddr (w_addr[g]),
                .o_rdata (w_q[g])
            );

            // the instruction retiring on the read edge is caught by the bypass
            always_ff @(posedge i_clk) begin
                if (i_rd_en) begin
                    r_fwd_hit[g] <= i_wr.en && (i_wr.addr == w_addr[g]);
                    r_vld[g]     <= r_valid[w_addr[g]];
                    r_is_pc[g]   <= (w_addr[g] == PC_IDX);
                end
            end

            always_comb begin
                if (r_is_pc[g]) begin
                    w_val[g] = pc_plus(i_pc, 24'd2);
                end else if (r_fwd_hit[g]) begin
                    w_val[g] = r_fwd_data;
                end else if (r_vld[g]) begin
                    w_val[g] = w_q[g];
                end else begin
                    w_val[g] = '0;
                end
            end
        end
    endgenerate

    assign o_ops.m = w_val[PORT_M];
    assign o_ops.s = w_val[PORT_S];
    assign o_ops.c = w_val[PORT_C];

endmodule

FILE: src/a2x_alu.sv
// execute logic: condition test, shifter, alu, multiply, branch and next state
`timescale 1ns / 1ps

module a2x_alu (
    input  logic [31:0]         i_word,
    input  a2x_pkg::t_operands  i_ops,
    input  logic [31:0]         i_pc,
    input  a2x_pkg::t_flags     i_flags,
    output a2x_pkg::t_exec      o_res
);
    import a2x_pkg::*;

    logic [WORD_W-1:0] w_prod;
    logic [WORD_W-1:0] w_macc;

    assign w_prod = i_ops.m * i_ops.s;
    assign w_macc = w_prod + (i_word[21] ? i_ops.c : '0);

    always_comb begin
        t_dp_op              op;
        logic                s;
        logic [3:0]          rd;
        logic [3:0]          rdm;
        logic [WORD_W-1:0]   b;
        logic [WORD_W-1:0]   x;
        logic [WORD_W-1:0]   y;
        logic [WORD_W-1:0]   res;
        logic [WORD_W:0]     sum;
        logic                xcin;
        logic                sc;
        logic                ac;
        logic                av;
        logic                is_logic;
        logic [4:0]          rot;
        logic [2*WORD_W-1:0] rr;
        t_shift_out          sho;
        t_flags              nf;

        op = t_dp_op'(i_word[24:21]);
        s = i_word[20];
        rd = i_word[15:12];
        rdm = i_word[19:16];
        is_logic = LOGIC_OPS[i_word[24:21]];
        rot = {i_word[11:8], 1'b0};
        rr = {24'd0, i_word[7:0], 24'd0, i_word[7:0]} >> rot;
        sho = '0;

        // second operand
        if (i_word[25]) begin
            b = rr[31:0];
            sc = (rot != 5'd0) ? b[31] : i_flags.c;
        end else begin
            if (i_word[4]) begin
                sho = barrel(i_ops.m, t_shift'(i_word[6:5]), i_ops.s[7:0], 1'b1, i_flags.c);
            end else begin
                sho = barrel(i_ops.m, t_shift'(i_word[6:5]), {3'd0, i_word[11:7]}, 1'b0,
                             i_flags.c);
            end
            b = sho.value;
            sc = sho.carry;
        end

        case (op)
            OP_SUB, OP_CMP: begin x = i_ops.c; y = ~b;       xcin = 1'b1;      end
            OP_RSB:         begin x = b;       y = ~i_ops.c; xcin = 1'b1;      end
            OP_ADC:         begin x = i_ops.c; y = b;        xcin = i_flags.c; end
            OP_SBC:         begin x = i_ops.c; y = ~b;       xcin = i_flags.c; end
            OP_RSC:         begin x = b;       y = ~i_ops.c; xcin = i_flags.c; end
            default:        begin x = i_ops.c; y = b;        xcin = 1'b0;      end
        endcase
        sum = {1'b0, x} + {1'b0, y} + {32'd0, xcin};
        ac = sum[32];
        av = ~(x[31] ^ y[31]) & (x[31] ^ sum[31]);

        case (op)
            OP_AND, OP_TST: res = i_ops.c & b;
            OP_EOR, OP_TEQ: res = i_ops.c ^ b;
            OP_ORR:         res = i_ops.c | b;
            OP_MOV:         res = b;
            OP_BIC:         res = i_ops.c & ~b;
            OP_MVN:         res = ~b;
            default:        res = sum[31:0];
        endcase

        nf.n = res[31];
        nf.z = (res == '0);
        nf.c = is_logic ? sc : ac;
        nf.v = is_logic ? i_flags.v : av;

        o_res = '0;
        o_res.outcome = OUT_UNSUP;
        o_res.flags = i_flags;
        o_res.pc_word = i_pc;

        if (!cond_pass(t_cond'(i_word[31:28]), i_flags)) begin
            o_res.outcome = OUT_SKIP;
            o_res.pc_word = pc_plus(i_pc, 24'd1);
        end else if (is_mul(i_word)) begin
            o_res.outcome = OUT_MUL;
            o_res.reg_written = 1'b1;
            o_res.dest_index = rdm;
            if (rdm == PC_IDX) begin
                o_res.pc_word = (i_pc & PC_KEEP) | (w_macc & PC_FIELD);
                o_res.dest_value = (i_pc & PC_KEEP) | (w_macc & PC_FIELD);
            end else begin
                o_res.dest_value = w_macc;
                o_res.pc_word = pc_plus(i_pc, 24'd1);
            end
            if (s) begin
                o_res.flags.n = w_macc[31];
                o_res.flags.z = (w_macc == '0);
            end
        end else if (is_branch(i_word)) begin
            o_res.outcome = OUT_BRANCH;
            if (i_word[24]) begin
                o_res.reg_written = 1'b1;
                o_res.dest_index = LINK_IDX;
                o_res.dest_value = pc_plus(i_pc, 24'd1);
            end
            o_res.pc_word = {i_pc[31:26], i_pc[25:2] + 24'd2 + i_word[23:0], i_pc[1:0]};
        end else if (is_dp(i_word)) begin
            o_res.outcome = OUT_DP;
            if (op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN}) begin
                if (s) begin
                    o_res.flags = nf;
                end
                o_res.pc_word = pc_plus(i_pc, 24'd1);
            end else if (rd == PC_IDX) begin
                o_res.reg_written = 1'b1;
                o_res.dest_index = PC_IDX;
                if (s) begin
                    // psr form: top nibble also lands in the flags
                    o_res.pc_word = (i_pc & PSR_KEEP) | (res & ~PSR_KEEP);
                    o_res.flags = t_flags'(res[31:28]);
                end else begin
                    o_res.pc_word = (i_pc & PC_KEEP) | (res & PC_FIELD);
                end
                o_res.dest_value = o_res.pc_word;
            end else begin
                o_res.reg_written = 1'b1;
                o_res.dest_index = rd;
                o_res.dest_value = res;
                if (s) begin
                    o_res.flags = nf;
                end
                o_res.pc_word = pc_plus(i_pc, 24'd1);
            end
        end
    end

endmodule

FILE: src/arm2_conditional_execute_unit.sv
// top level of the arm2 conditional execute unit
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+----------------------------------------------
//  i_in     | in  | valid / ready | instruction_word[31:0]
//  o_res    | out | valid / ready | outcome, reg_written, dest_index, dest_value,
//           |     |               | flag_n..flag_v, pc_word
//
// one instruction per cycle while o_res is not stalled: a beat is taken into the execute
// register, its operands come from the register file read on the accept edge, and the
// result register loads from the execute stage when the beat fires.
// the execute register and the result register lie between a beat and its result.
// synchronous active-low reset clears r15, the flags and the register valid bits.
// when o_res stalls the execute register holds; a new beat still enters
// while the execute register is empty.
`timescale 1ns / 1ps

module arm2_conditional_execute_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    a2x_in_if.sink    i_in,
    a2x_out_if.source o_res
);
    import a2x_pkg::*;

    logic        r_e_valid;
    logic [31:0] r_e_word;
    logic        r_out_valid;
    t_exec       r_out;
    logic [31:0] r_pc;
    t_flags      r_flags;

    logic        w_accept;
    logic        w_fire;
    t_operands   w_ops;
    t_exec       w_exec;
    t_wr_port    w_wr;

    assign w_fire = r_e_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_e_valid || w_fire;
    assign w_accept = i_in.valid && i_in.ready;

    // r15 lives in flops, so only r0..r14 go to the ram
    assign w_wr.en = w_fire && w_exec.reg_written && (w_exec.dest_index != PC_IDX);
    assign w_wr.addr = w_exec.dest_index;
    assign w_wr.data = w_exec.dest_value;

    a2x_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (w_accept),
        .i_word  (i_in.instruction_word),
        .i_wr    (w_wr),
        .i_pc    (r_pc),
        .o_ops   (w_ops)
    );

    a2x_alu u_alu (
        .i_word  (r_e_word),
        .i_ops   (w_ops),
        .i_pc    (r_pc),
        .i_flags (r_flags),
        .o_res   (w_exec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc <= '0;
            r_flags <= '0;
        end else begin
            if (w_accept) begin
                r_e_valid <= 1'b1;
            end else if (w_fire) begin
                r_e_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_pc <= w_exec.pc_word;
                r_flags <= w_exec.flags;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e_word <= i_in.instruction_word;
        end
        if (w_fire) begin
            r_out <= w_exec;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.outcome = r_out.outcome;
    assign o_res.reg_written = r_out.reg_written;
    assign o_res.dest_index = r_out.dest_index;
    assign o_res.dest_value = r_out.dest_value;
    assign o_res.flag_n = r_out.flags.n;
    assign o_res.flag_z = r_out.flags.z;
    assign o_res.flag_c = r_out.flags.c;
    assign o_res.flag_v = r_out.flags.v;
    assign o_res.pc_word = r_out.pc_word;

endmodule

FILE: src/a2x_checker.sv
// port-level checks on the result channel, bound to the top level
`timescale 1ns / 1ps

module a2x_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    a2x_out_if.source i_res
);
    import a2x_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_res.valid)
        else $error("result beat valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid && !i_res.ready |=>
            i_res.valid && $stable(i_res.outcome) && $stable(i_res.dest_value)
            && $stable(i_res.pc_word))
        else $error("stalled result beat changed");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid && !i_res.reg_written |->
            i_res.dest_index == 4'd0 && i_res.dest_value == 32'd0)
        else $error("destination fields set without a register write");

    a_pc_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid && i_res.reg_written && i_res.dest_index == PC_IDX |->
            i_res.dest_value == i_res.pc_word)
        else $error("r15 write value differs from pc word");

    a_idle_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res.valid && (i_res.outcome == OUT_SKIP || i_res.outcome == OUT_UNSUP) |->
            !i_res.reg_written)
        else $error("skipped or unsupported instruction wrote a register");

endmodule

bind arm2_conditional_execute_unit a2x_checker u_a2x_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_res   (o_res)
);
